### rtl/core/block_rotate_xor_mixer_defines.svh
// Assertion macros shared by the mixer RTL.
// Each use expects clk and rst_n in scope.
`ifndef BLOCK_ROTATE_XOR_MIXER_DEFINES_SVH
`define BLOCK_ROTATE_XOR_MIXER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define BRMX_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("brmx: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define BRMX_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("brmx: next-cycle check failed");

`endif

### rtl/core/brmx_pkg.sv
package brmx_pkg;

    // Block geometry
    localparam int BLOCK_BYTES = 64;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int FILL_W      = 7;

    // Mixing taps; the near tap is rebuilt from a delayed copy of the port A read
    localparam int TAP_A   = 7;
    localparam int TAP_B   = 11;
    localparam int TAP_LAG = TAP_B - TAP_A;

    // Back-end step counter covers the block plus the tap lead-in
    localparam int CNT_W = $clog2(BLOCK_BYTES + TAP_LAG + 1);

    // Queue depth
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic
    {
        DESC_PART = 1'b0,
        DESC_FULL = 1'b1
    } desc_kind_t;

    // Work descriptor handed from front to back
    typedef struct packed
    {
        desc_kind_t          kind;
        logic [FILL_W-1:0]   count;
        logic                last;
    } desc_t;

    // Store write port
    typedef struct packed
    {
        logic               en;
        logic [ADDR_W-1:0]  addr;
        logic [7:0]         data;
    } store_wr_t;

    // Queue status seen by front and back
    typedef struct packed
    {
        logic empty;
        logic full;
    } queue_stat_t;

    typedef enum logic
    {
        BACK_IDLE = 1'b0,
        BACK_RUN  = 1'b1
    } back_state_t;

endpackage

### rtl/core/brmx_store.sv
module brmx_store
(
    input  logic                          clk,
    input  brmx_pkg::store_wr_t           wr,
    input  logic [brmx_pkg::ADDR_W-1:0]   rd_addr_a,
    input  logic [brmx_pkg::ADDR_W-1:0]   rd_addr_b,
    output logic [7:0]                    rd_data_a,
    output logic [7:0]                    rd_data_b
);

    logic [7:0] mem [brmx_pkg::STORE_DEPTH];

    // Write one byte per transfer
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Register both read ports
    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

### rtl/core/brmx_queue.sv
`include "block_rotate_xor_mixer_defines.svh"

module brmx_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  brmx_pkg::desc_t        push_desc,
    input  logic                   pop,
    output brmx_pkg::desc_t        head,
    output brmx_pkg::queue_stat_t  stat
);

    brmx_pkg::desc_t                  slot_reg [brmx_pkg::QUEUE_DEPTH];
    logic [brmx_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [brmx_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [brmx_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [brmx_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [brmx_pkg::QCNT_W-1:0]      cnt_reg;
    logic [brmx_pkg::QCNT_W-1:0]      cnt_next;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + brmx_pkg::QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + brmx_pkg::QPTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + brmx_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - brmx_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold descriptors
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

    assign head       = slot_reg[rd_ptr_reg];
    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == brmx_pkg::QCNT_W'(brmx_pkg::QUEUE_DEPTH));

    `BRMX_ASSERT_SAME(a_no_push_full, push, !stat.full)
    `BRMX_ASSERT_SAME(a_no_pop_empty, pop, !stat.empty)
    `BRMX_ASSERT_SAME(a_full_not_empty, stat.full, !stat.empty)

endmodule

### rtl/core/brmx_front.sv
module brmx_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [7:0]             data_byte,
    input  logic                   buffer_end,
    input  brmx_pkg::queue_stat_t  q_stat,
    input  logic                   back_run,
    output logic                   busy,
    output brmx_pkg::store_wr_t    store_wr,
    output logic                   push,
    output brmx_pkg::desc_t        push_desc
);

    logic [brmx_pkg::FILL_W-1:0] fill_reg;
    logic [brmx_pkg::FILL_W-1:0] fill_next;
    logic [brmx_pkg::FILL_W-1:0] pos;
    logic [brmx_pkg::FILL_W-1:0] n;
    logic                        accept;
    logic                        complete;

    // Stall while any block or flush is pending in the back end
    assign busy   = !q_stat.empty || back_run;
    assign accept = start && !busy;

    // Classify the byte: gather, complete a block, or flush a partial one
    always_comb
    begin
        pos = fill_reg;
        if (fill_reg >= brmx_pkg::FILL_W'(brmx_pkg::BLOCK_BYTES))
        begin
            pos = '0;
        end
        n        = pos + brmx_pkg::FILL_W'(1);
        complete = (n >= brmx_pkg::FILL_W'(brmx_pkg::BLOCK_BYTES));

        push            = accept && (complete || buffer_end);
        push_desc.kind  = complete ? brmx_pkg::DESC_FULL : brmx_pkg::DESC_PART;
        push_desc.count = n;
        push_desc.last  = buffer_end;

        store_wr.en   = accept;
        store_wr.addr = pos[brmx_pkg::ADDR_W-1:0];
        store_wr.data = data_byte;

        fill_next = fill_reg;
        if (accept)
        begin
            fill_next = (complete || buffer_end) ? '0 : n;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

endmodule

### rtl/core/brmx_back.sv
`include "block_rotate_xor_mixer_defines.svh"

module brmx_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  brmx_pkg::desc_t               head,
    input  brmx_pkg::queue_stat_t         q_stat,
    output logic                          pop,
    output logic                          back_run,
    output logic [brmx_pkg::ADDR_W-1:0]   rd_addr_a,
    output logic [brmx_pkg::ADDR_W-1:0]   rd_addr_b,
    input  logic [7:0]                    rd_data_a,
    input  logic [7:0]                    rd_data_b,
    output logic                          strobe,
    output logic [7:0]                    mixed_byte,
    output logic                          run_last,
    output logic                          buffer_last
);

    localparam logic [brmx_pkg::CNT_W-1:0] FULL_END =
        brmx_pkg::CNT_W'(brmx_pkg::BLOCK_BYTES + brmx_pkg::TAP_LAG - 1);

    brmx_pkg::back_state_t          state_reg;
    brmx_pkg::back_state_t          state_next;
    brmx_pkg::desc_t                desc_reg;
    logic [brmx_pkg::CNT_W-1:0]     step_reg;
    logic [brmx_pkg::CNT_W-1:0]     step_next;
    logic [brmx_pkg::CNT_W:0]       lead_sum;
    logic [brmx_pkg::CNT_W-1:0]     b_index;
    logic                           is_full;
    logic                           issue_end;
    logic                           issue_emit;
    logic [7:0]                     tap_reg [brmx_pkg::TAP_LAG];
    logic                           p_valid_reg;
    logic                           p_end_reg;
    logic                           p_buf_reg;
    logic                           p_full_reg;
    logic                           strobe_reg;
    logic [7:0]                     mixed_reg;
    logic                           run_last_reg;
    logic                           buf_last_reg;

    assign is_full = (desc_reg.kind == brmx_pkg::DESC_FULL);

    // Detect the final read of the current descriptor
    always_comb
    begin
        if (is_full)
        begin
            issue_end = (step_reg == FULL_END);
        end
        else
        begin
            issue_end = (step_reg == brmx_pkg::CNT_W'(desc_reg.count) - brmx_pkg::CNT_W'(1));
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            brmx_pkg::BACK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = brmx_pkg::BACK_RUN;
                end
            end
            brmx_pkg::BACK_RUN:
            begin
                if (issue_end)
                begin
                    state_next = brmx_pkg::BACK_IDLE;
                end
            end
            default:
            begin
                state_next = brmx_pkg::BACK_IDLE;
            end
        endcase
    end

    // State outputs and step counter
    always_comb
    begin
        pop        = 1'b0;
        back_run   = 1'b0;
        issue_emit = 1'b0;
        step_next  = step_reg;
        unique case (state_reg)
            brmx_pkg::BACK_IDLE:
            begin
                pop       = !q_stat.empty;
                step_next = '0;
            end
            brmx_pkg::BACK_RUN:
            begin
                back_run   = 1'b1;
                issue_emit = !is_full ||
                             (step_reg >= brmx_pkg::CNT_W'(brmx_pkg::TAP_LAG));
                step_next  = step_reg + brmx_pkg::CNT_W'(1);
            end
            default:
            begin
                step_next = '0;
            end
        endcase
    end

    // Read addresses: port A leads the step count by the near tap, port B walks the block
    always_comb
    begin
        lead_sum = {1'b0, step_reg} + (brmx_pkg::CNT_W + 1)'(brmx_pkg::TAP_A);
        if (lead_sum >= (brmx_pkg::CNT_W + 1)'(brmx_pkg::BLOCK_BYTES))
        begin
            lead_sum = lead_sum - (brmx_pkg::CNT_W + 1)'(brmx_pkg::BLOCK_BYTES);
        end
        b_index = is_full ? step_reg - brmx_pkg::CNT_W'(brmx_pkg::TAP_LAG) : step_reg;
        rd_addr_a = lead_sum[brmx_pkg::ADDR_W-1:0];
        rd_addr_b = b_index[brmx_pkg::ADDR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= brmx_pkg::BACK_IDLE;
            step_reg    <= '0;
            p_valid_reg <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            p_valid_reg <= issue_emit;
            strobe_reg  <= p_valid_reg;
        end
    end

    // Latch the descriptor on pop
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            desc_reg <= head;
        end
    end

    // Delay port A reads to rebuild the near tap; track flags beside the read
    always_ff @(posedge clk)
    begin
        tap_reg[0] <= rd_data_a;
        for (int k = 1; k < brmx_pkg::TAP_LAG; k++)
        begin
            tap_reg[k] <= tap_reg[k-1];
        end
        p_end_reg  <= issue_end;
        p_buf_reg  <= issue_end && desc_reg.last;
        p_full_reg <= is_full;
    end

    // Mix or pass through, then register the result
    always_ff @(posedge clk)
    begin
        if (p_full_reg)
        begin
            mixed_reg <= rd_data_b ^ tap_reg[brmx_pkg::TAP_LAG-1] ^ rd_data_a;
        end
        else
        begin
            mixed_reg <= rd_data_b;
        end
        run_last_reg <= p_end_reg;
        buf_last_reg <= p_buf_reg;
    end

    assign strobe      = strobe_reg;
    assign mixed_byte  = mixed_reg;
    assign run_last    = run_last_reg;
    assign buffer_last = buf_last_reg;

    `BRMX_ASSERT_NEXT(a_pop_starts_run, pop, state_reg == brmx_pkg::BACK_RUN)
    `BRMX_ASSERT_NEXT(a_end_reaches_out, p_valid_reg && p_end_reg, strobe && run_last)
    `BRMX_ASSERT_SAME(a_buf_last_on_run_end, strobe && buffer_last, run_last)

endmodule

### rtl/core/block_rotate_xor_mixer.sv
// Output: each descriptor is popped and its bytes read from the store's registered
// ports, then pass the flag stage and output register; full blocks add the tap lead-in.
// Throughput: one byte per cycle in while busy is low, and out while a block drains;
// busy holds through the pop, any tap lead-in and the reads of each block or flush.
// The store's two registered read ports set the emit rate; the receiver cannot stall.
// Reset clears the fill count, queue and back-end control; block contents are not reset.
module block_rotate_xor_mixer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  data_byte,
    input  logic        buffer_end,
    output logic        strobe,
    output logic [7:0]  mixed_byte,
    output logic        run_last,
    output logic        buffer_last
);

    brmx_pkg::queue_stat_t          q_stat;
    brmx_pkg::desc_t                push_desc;
    brmx_pkg::desc_t                head;
    brmx_pkg::store_wr_t            store_wr;
    logic                           push;
    logic                           pop;
    logic                           back_run;
    logic [brmx_pkg::ADDR_W-1:0]    rd_addr_a;
    logic [brmx_pkg::ADDR_W-1:0]    rd_addr_b;
    logic [7:0]                     rd_data_a;
    logic [7:0]                     rd_data_b;

    brmx_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .data_byte  (data_byte),
        .buffer_end (buffer_end),
        .q_stat     (q_stat),
        .back_run   (back_run),
        .busy       (busy),
        .store_wr   (store_wr),
        .push       (push),
        .push_desc  (push_desc)
    );

    brmx_store u_store
    (
        .clk       (clk),
        .wr        (store_wr),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    brmx_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    brmx_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_stat      (q_stat),
        .pop         (pop),
        .back_run    (back_run),
        .rd_addr_a   (rd_addr_a),
        .rd_addr_b   (rd_addr_b),
        .rd_data_a   (rd_data_a),
        .rd_data_b   (rd_data_b),
        .strobe      (strobe),
        .mixed_byte  (mixed_byte),
        .run_last    (run_last),
        .buffer_last (buffer_last)
    );

endmodule
